// File: hw/rtl/hsort_pkg.sv
package hsort_pkg;

  localparam int unsigned CAPACITY   = 64;
  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned INDEX_BITS = 10;

  localparam int unsigned ADDR_W  = $clog2(CAPACITY);
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);
  localparam int unsigned KID_W   = CNT_W + 1;
  localparam int unsigned ENTRY_W = KEY_BITS + 2 * INDEX_BITS;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [KID_W-1:0]  kid_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   sort_key;
    logic [INDEX_BITS-1:0] cell_row;
    logic [INDEX_BITS-1:0] cell_col;
    logic                  last_item;
  } in_item_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   sorted_key;
    logic [INDEX_BITS-1:0] out_row;
    logic [INDEX_BITS-1:0] out_col;
    logic [CNT_W-1:0]      rank;
    logic                  overflow;
    logic                  dropped_items;
    logic                  last_result;
  } out_item_t;

  // one stored heap entry
  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [INDEX_BITS-1:0] row;
    logic [INDEX_BITS-1:0] col;
  } entry_t;

  typedef struct packed {
    logic   we;
    addr_t  waddr;
    entry_t wdata;
    addr_t  raddr_a;
    addr_t  raddr_b;
  } mem_req_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } emit_t;

endpackage

// File: hw/rtl/hsort_if.sv
interface hsort_in_if import hsort_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hsort_out_if import hsort_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/heap_sort_with_position_map.sv
// Loading: one beat per cycle; a set of n items closes on the beat with last_item.
// Sorting: in-place heapsort in a dual-read RAM; each sift level reads both
//   children (S_SIFT) and then compares and writes back (S_CMP).
// Emission: each result is read from the RAM, then taken into the output register.
// A new set is accepted only after the last result of the current set is emitted.
// Reset clears control state and the item count; RAM contents are not cleared.
module heap_sort_with_position_map import hsort_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  hsort_in_if.sink    in_i,
  hsort_out_if.source out_o
);

  mem_req_t  mem_req;
  entry_t    rd_a;
  entry_t    rd_b;
  emit_t     emit;
  logic      in_ready;
  logic      out_free;
  logic      out_valid_q;
  out_item_t out_item_q;

  assign out_free = !out_valid_q || out_o.ready;

  hsort_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_item_i  (in_i.data),
    .in_ready_o (in_ready),
    .rd_a_i     (rd_a),
    .rd_b_i     (rd_b),
    .mem_o      (mem_req),
    .out_free_i (out_free),
    .emit_o     (emit)
  );

  hsort_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (mem_req.we),
    .waddr_i   (mem_req.waddr),
    .wdata_i   (mem_req.wdata),
    .raddr_a_i (mem_req.raddr_a),
    .raddr_b_i (mem_req.raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_item_q <= emit.item;
    end
  end

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_item_q;

  // a new result never lands on one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.valid |-> (!out_valid_q || $past(out_free)))
    else $error("result register overwritten");

  // loading and emission never overlap
  a_load_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready |-> !emit.valid)
    else $error("input taken during emission");

  // the final result of a run hands control back to loading
  a_last_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit.valid && emit.item.last_result) |=> in_ready)
    else $error("block not ready after last result");

  // every emitted rank is in 1..CAPACITY
  a_rank_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.valid |-> (emit.item.rank != '0 && emit.item.rank <= CNT_W'(CAPACITY)))
    else $error("rank out of range");

endmodule

// File: hw/rtl/hsort_ram.sv
module hsort_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// File: hw/rtl/hsort_ctrl.sv
module hsort_ctrl import hsort_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_item_t in_item_i,
  output logic     in_ready_o,
  input  entry_t   rd_a_i,
  input  entry_t   rd_b_i,
  output mem_req_t mem_o,
  input  logic     out_free_i,
  output emit_t    emit_o
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_OUTER,
    S_TAKE_LO,
    S_TAKE_HI,
    S_SIFT,
    S_CMP,
    S_FINAL,
    S_EMIT_RD,
    S_EMIT_WR
  } state_e;

  state_e state_q, state_d;
  cnt_t   cnt_q, cnt_d;
  logic   ovf_q, ovf_d;
  cnt_t   lo_q, lo_d;
  cnt_t   hi_q, hi_d;
  cnt_t   at_q, at_d;
  cnt_t   k_q, k_d;
  entry_t hk_q, hk_d;

  kid_t   kid;
  kid_t   hi_ext;
  logic   take_b;
  entry_t pick;
  kid_t   pick_pos;
  cnt_t   cnt_inc;

  assign kid      = {at_q, 1'b0};
  assign hi_ext   = {1'b0, hi_q};
  // right child only exists while kid < hi
  assign take_b   = (kid < hi_ext) && (rd_a_i.key < rd_b_i.key);
  assign pick     = take_b ? rd_b_i : rd_a_i;
  assign pick_pos = take_b ? kid + KID_W'(1) : kid;
  assign cnt_inc  = cnt_q + CNT_W'(1);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    at_d       = at_q;
    k_d        = k_q;
    hk_d       = hk_q;
    mem_o      = '0;
    in_ready_o = 1'b0;
    emit_o     = '0;

    unique case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (cnt_q < CNT_W'(CAPACITY)) begin
            mem_o.we    = 1'b1;
            mem_o.waddr = cnt_q[ADDR_W-1:0];
            mem_o.wdata = '{key: in_item_i.sort_key, row: in_item_i.cell_row,
                            col: in_item_i.cell_col};
            cnt_d       = cnt_inc;
          end else begin
            ovf_d = 1'b1;
          end
          if (in_item_i.last_item) begin
            k_d = '0;
            if (cnt_d < CNT_W'(2)) begin
              state_d = S_EMIT_RD;
            end else begin
              lo_d    = (cnt_d >> 1) + CNT_W'(1);
              hi_d    = cnt_d;
              state_d = S_OUTER;
            end
          end
        end
      end
      S_OUTER: begin
        if (lo_q > CNT_W'(1)) begin
          lo_d          = lo_q - CNT_W'(1);
          mem_o.raddr_a = ADDR_W'(lo_q - CNT_W'(2));
          state_d       = S_TAKE_LO;
        end else begin
          mem_o.raddr_a = ADDR_W'(hi_q - CNT_W'(1));
          mem_o.raddr_b = '0;
          state_d       = S_TAKE_HI;
        end
      end
      S_TAKE_LO: begin
        hk_d    = rd_a_i;
        at_d    = lo_q;
        state_d = S_SIFT;
      end
      S_TAKE_HI: begin
        // root moves to the tail, old tail becomes the sift item
        hk_d        = rd_a_i;
        mem_o.we    = 1'b1;
        mem_o.waddr = ADDR_W'(hi_q - CNT_W'(1));
        mem_o.wdata = rd_b_i;
        hi_d        = hi_q - CNT_W'(1);
        if (hi_q == CNT_W'(2)) begin
          state_d = S_FINAL;
        end else begin
          at_d    = CNT_W'(1);
          state_d = S_SIFT;
        end
      end
      S_SIFT: begin
        if (kid > hi_ext) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = ADDR_W'(at_q - CNT_W'(1));
          mem_o.wdata = hk_q;
          state_d     = S_OUTER;
        end else begin
          mem_o.raddr_a = ADDR_W'(kid - KID_W'(1));
          mem_o.raddr_b = ADDR_W'(kid);
          state_d       = S_CMP;
        end
      end
      S_CMP: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = ADDR_W'(at_q - CNT_W'(1));
        if (hk_q.key >= pick.key) begin
          mem_o.wdata = hk_q;
          state_d     = S_OUTER;
        end else begin
          mem_o.wdata = pick;
          at_d        = CNT_W'(pick_pos);
          state_d     = S_SIFT;
        end
      end
      S_FINAL: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = '0;
        mem_o.wdata = hk_q;
        k_d         = '0;
        state_d     = S_EMIT_RD;
      end
      S_EMIT_RD: begin
        // only fetch when the output register will be empty next cycle
        if (out_free_i) begin
          mem_o.raddr_a = k_q[ADDR_W-1:0];
          state_d       = S_EMIT_WR;
        end
      end
      S_EMIT_WR: begin
        emit_o.valid              = 1'b1;
        emit_o.item.sorted_key    = rd_a_i.key;
        emit_o.item.out_row       = rd_a_i.row;
        emit_o.item.out_col       = rd_a_i.col;
        emit_o.item.rank          = k_q + CNT_W'(1);
        emit_o.item.overflow      = 1'b0;
        emit_o.item.dropped_items = ovf_q;
        emit_o.item.last_result   = (k_q + CNT_W'(1)) == cnt_q;
        if ((k_q + CNT_W'(1)) == cnt_q) begin
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = S_LOAD;
        end else begin
          k_d     = k_q + CNT_W'(1);
          state_d = S_EMIT_RD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      lo_q    <= '0;
      hi_q    <= '0;
      at_q    <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      at_q    <= at_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hk_q <= hk_d;
  end

endmodule
